@@ rtl/crr_pkg.sv @@
// ----------------------------------------------------------------------------
// crr_pkg
// Shared types and codes for the cascaded range remapper: action codes,
// sequencer states and the layout of one stored range entry.
// ----------------------------------------------------------------------------
`default_nettype none

package crr_pkg;

    localparam int WORD_W   = 32;
    localparam int ACTION_W = 2;
    localparam int STAGE_W  = 3;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    // action codes carried in tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_XLATE = 2'd2
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_STAGE,
        ST_SCAN,
        ST_FINISH,
        ST_RESP
    } state_t;

    // one stored range entry
    typedef struct packed {
        logic [WORD_W-1:0] source;
        logic [WORD_W-1:0] dest;
        logic [WORD_W-1:0] length;
    } entry_t;

    // result of checking one entry against a value
    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] mapped;
    } match_t;

endpackage

`default_nettype wire

@@ rtl/crr_entry_ram.sv @@
// ----------------------------------------------------------------------------
// crr_entry_ram
// Entry table for all stages: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_entry_ram
    import crr_pkg::*;
#(
    parameter int DEPTH  = 224,
    parameter int ADDR_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/crr_range_unit.sv @@
// ----------------------------------------------------------------------------
// crr_range_unit
// Shared range check: tests one entry against the running value and forms
// the saturated destination.
// ----------------------------------------------------------------------------
`default_nettype none

module crr_range_unit
    import crr_pkg::*;
(
    input  wire logic [WORD_W-1:0] value,
    input  wire entry_t            entry,
    output match_t                 result
);

    logic [WORD_W-1:0] offset;
    logic [WORD_W:0]   sum;

    // offset into the source range and shifted destination
    always_comb begin
        offset        = value - entry.source;
        sum           = {1'b0, entry.dest} + {1'b0, offset};
        result.hit    = (value >= entry.source) && (offset < entry.length);
        result.mapped = sum[WORD_W] ? ALL_ONES : sum[WORD_W-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/cascaded_range_remapper_unit.sv @@
// ----------------------------------------------------------------------------
// cascaded_range_remapper_unit
// Chain of range translation stages sharing one entry table and one range
// check unit under a small sequencer.
// ----------------------------------------------------------------------------
// A word is taken only while the sequencer is idle and one result word is
// returned per input word. A translate walks the stages in order: the single
// read port of the entry table delivers one entry per cycle to the shared
// range unit, each stage starts its scan in ST_STAGE and an empty stage is
// skipped. A finished result sits in an output register, so the next word
// may be taken while it waits. The entry table has no reset; only fill
// counts are cleared.
`default_nettype none

module cascaded_range_remapper_unit
    import crr_pkg::*;
#(
    parameter int STAGE_COUNT       = 7,
    parameter int ENTRIES_PER_STAGE = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // stage[2:0], source_start[34:3], dest_start[66:35],
    // range_length[98:67], value[130:99], zero pad
    input  wire logic [135:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // mapped_value[31:0], lowest_seen[63:32], status[64], zero pad
    output logic [71:0]       m_axis_tdata
);

    localparam int SLOT_TOTAL = STAGE_COUNT * ENTRIES_PER_STAGE;
    localparam int SLOT_W     = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int STG_W      = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int FILL_W     = $clog2(ENTRIES_PER_STAGE + 1);

    state_t state_reg, state_next;

    // captured input word
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [STAGE_W-1:0]  stage_reg, stage_next;
    entry_t              load_reg, load_next;
    logic [WORD_W-1:0]   value_reg, value_next;

    // scan position
    logic [STG_W-1:0]  sidx_reg, sidx_next;
    logic [SLOT_W-1:0] base_reg, base_next;
    logic [FILL_W-1:0] k_reg, k_next;

    // table fill and running minimum
    logic [FILL_W-1:0] fill_reg [STAGE_COUNT];
    logic [FILL_W-1:0] fill_next [STAGE_COUNT];
    logic [WORD_W-1:0] min_reg, min_next;
    logic              status_reg, status_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_mapped_reg, m_mapped_next;
    logic [WORD_W-1:0] m_lowest_reg, m_lowest_next;
    logic              m_status_reg, m_status_next;

    // table ports
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            rd_data;
    match_t            match;

    logic              s_fire;
    logic              stage_ok;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_load;
    logic              last_stage;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_status_reg, m_lowest_reg, m_mapped_reg};

    assign stage_ok   = (32'(stage_reg) < STAGE_COUNT);
    assign fill_load  = fill_reg[STG_W'(stage_reg)];
    assign fill_cur   = fill_reg[sidx_reg];
    assign last_stage = (sidx_reg == STG_W'(STAGE_COUNT - 1));

    crr_entry_ram #(
        .DEPTH  (SLOT_TOTAL),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (load_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crr_range_unit u_range (
        .value  (value_reg),
        .entry  (rd_data),
        .result (match)
    );

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            min_reg     <= ALL_ONES;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < STAGE_COUNT; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
            fill_reg    <= fill_next;
        end
    end

    // payload and scan registers
    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        stage_reg    <= stage_next;
        load_reg     <= load_next;
        value_reg    <= value_next;
        sidx_reg     <= sidx_next;
        base_reg     <= base_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
        m_mapped_reg <= m_mapped_next;
        m_lowest_reg <= m_lowest_next;
        m_status_reg <= m_status_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        stage_next    = stage_reg;
        load_next     = load_reg;
        value_next    = value_reg;
        sidx_next     = sidx_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        fill_next     = fill_reg;
        min_next      = min_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_mapped_next = m_mapped_reg;
        m_lowest_next = m_lowest_reg;
        m_status_next = m_status_reg;
        wr_en         = 1'b0;
        wr_addr       = SLOT_W'(32'(stage_reg) * ENTRIES_PER_STAGE) + SLOT_W'(fill_load);
        rd_en         = 1'b0;
        rd_addr       = base_reg;

        // result taken downstream
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    action_next    = s_axis_tuser;
                    stage_next     = s_axis_tdata[2:0];
                    load_next      = '{source: s_axis_tdata[34:3],
                                       dest:   s_axis_tdata[66:35],
                                       length: s_axis_tdata[98:67]};
                    value_next     = s_axis_tdata[130:99];
                    sidx_next      = '0;
                    base_next      = '0;
                    k_next         = '0;
                    status_next    = 1'b0;
                    case (s_axis_tuser)
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_LOAD:  state_next = ST_LOAD;
                        ACT_XLATE: state_next = ST_STAGE;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end

            // empty every table and reset the minimum
            ST_CLEAR: begin
                for (int i = 0; i < STAGE_COUNT; i++) begin
                    fill_next[i] = '0;
                end
                min_next   = ALL_ONES;
                state_next = ST_RESP;
            end

            // append an entry unless the stage is bad or full
            ST_LOAD: begin
                if (!stage_ok) begin
                    status_next = 1'b1;
                end else if (fill_load == FILL_W'(ENTRIES_PER_STAGE)) begin
                    status_next = 1'b1;
                end else begin
                    wr_en                          = 1'b1;
                    fill_next[STG_W'(stage_reg)] = fill_load + 1'b1;
                end
                state_next = ST_RESP;
            end

            // start scan of the current stage, skip an empty one
            ST_STAGE: begin
                if (fill_cur != '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = base_reg;
                    k_next     = '0;
                    state_next = ST_SCAN;
                end else if (last_stage) begin
                    state_next = ST_FINISH;
                end else begin
                    sidx_next  = sidx_reg + 1'b1;
                    base_next  = base_reg + SLOT_W'(ENTRIES_PER_STAGE);
                    state_next = ST_STAGE;
                end
            end

            // check one entry per cycle, prefetch the next one
            ST_SCAN: begin
                if (match.hit || (k_reg + 1'b1 == fill_cur)) begin
                    if (match.hit) begin
                        value_next = match.mapped;
                    end
                    if (last_stage) begin
                        state_next = ST_FINISH;
                    end else begin
                        sidx_next  = sidx_reg + 1'b1;
                        base_next  = base_reg + SLOT_W'(ENTRIES_PER_STAGE);
                        state_next = ST_STAGE;
                    end
                end else begin
                    k_next  = k_reg + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = base_reg + SLOT_W'(k_reg) + 1'b1;
                end
            end

            // fold the translated value into the minimum
            ST_FINISH: begin
                if (value_reg < min_reg) begin
                    min_next = value_reg;
                end
                state_next = ST_RESP;
            end

            // hand the result to the output register once it is free
            ST_RESP: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_mapped_next = (action_reg == ACT_XLATE) ? value_reg : '0;
                    m_lowest_next = min_reg;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a table write never goes past the end of its stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (stage_ok && (fill_load < FILL_W'(ENTRIES_PER_STAGE))))
        else $error("entry write into a full or missing stage");

    // the scan index stays below the fill of the stage being scanned
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (k_reg < fill_cur))
        else $error("scan ran past the stage fill");

    // an accepted word keeps the block busy on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |=> (m_valid_reg && $stable(m_axis_tdata)))
        else $error("pending result lost or changed");

endmodule

`default_nettype wire

@@ tb/remap_checker.sv @@
// ----------------------------------------------------------------------------
// remap_checker
// Watches both stream channels of the cascaded range remapper, keeps its own
// copy of the range tables and the running minimum, predicts one result word
// per accepted input word and compares every returned word field by field.
// ----------------------------------------------------------------------------
module remap_checker
    import crr_pkg::*;
#(
    parameter int STAGE_COUNT       = 7,
    parameter int ENTRIES_PER_STAGE = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // stage[2:0], source_start[34:3], dest_start[66:35],
    // range_length[98:67], value[130:99], zero pad
    input  logic [135:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mapped_value[31:0], lowest_seen[63:32], status[64], zero pad
    input  logic [71:0]  m_axis_tdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS     = STAGE_COUNT * ENTRIES_PER_STAGE;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [WORD_W-1:0] mapped;
        logic [WORD_W-1:0] lowest;
        logic              status;
    } remap_word_t;

    // shadow copy of the range tables
    logic [WORD_W-1:0] range_src [SLOTS];
    logic [WORD_W-1:0] range_dst [SLOTS];
    logic [WORD_W-1:0] range_len [SLOTS];
    int                stage_fill_q [STAGE_COUNT];
    logic [WORD_W-1:0] min_mapped;

    remap_word_t expected_words[$];

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    endtask

    // first matching entry of one stage moves the value, saturating on overflow
    function automatic logic [WORD_W-1:0] cross_stage(int s, logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] off;
        logic [WORD_W:0]   sum;
        int                slot;
        for (int k = 0; k < stage_fill_q[s]; k++) begin
            slot = s * ENTRIES_PER_STAGE + k;
            off  = v - range_src[slot];
            if (v >= range_src[slot] && off < range_len[slot]) begin
                sum = {1'b0, range_dst[slot]} + {1'b0, off};
                return sum[WORD_W] ? ALL_ONES : sum[WORD_W-1:0];
            end
        end
        return v;
    endfunction

    // apply one input word to the shadow state and return the expected word
    function automatic remap_word_t predict_word(logic [1:0] act, logic [2:0] stg,
                                                 logic [WORD_W-1:0] src,
                                                 logic [WORD_W-1:0] dst,
                                                 logic [WORD_W-1:0] len,
                                                 logic [WORD_W-1:0] val);
        remap_word_t w;
        int          slot;
        w = '0;
        case (act)
            ACT_CLEAR: begin
                foreach (stage_fill_q[s]) stage_fill_q[s] = 0;
                min_mapped = ALL_ONES;
            end
            ACT_LOAD: begin
                if (int'(stg) >= STAGE_COUNT || stage_fill_q[stg] >= ENTRIES_PER_STAGE) begin
                    w.status = 1'b1;
                end else begin
                    slot = int'(stg) * ENTRIES_PER_STAGE + stage_fill_q[stg];
                    range_src[slot] = src;
                    range_dst[slot] = dst;
                    range_len[slot] = len;
                    stage_fill_q[stg]++;
                end
            end
            ACT_XLATE: begin
                w.mapped = val;
                for (int s = 0; s < STAGE_COUNT; s++)
                    w.mapped = cross_stage(s, w.mapped);
                if (w.mapped < min_mapped)
                    min_mapped = w.mapped;
            end
            default: ;
        endcase
        w.lowest = min_mapped;
        return w;
    endfunction

    // predict on accepted input words, compare accepted result words
    always @(posedge aclk) begin : watch
        remap_word_t want;
        if (!aresetn) begin
            foreach (stage_fill_q[s]) stage_fill_q[s] = 0;
            min_mapped = ALL_ONES;
            expected_words.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata[31:0] !== want.mapped)
                        report_mismatch("mapped_value", m_axis_tdata[31:0], want.mapped);
                    if (m_axis_tdata[63:32] !== want.lowest)
                        report_mismatch("lowest_seen", m_axis_tdata[63:32], want.lowest);
                    if (m_axis_tdata[64] !== want.status)
                        report_mismatch("status", {31'd0, m_axis_tdata[64]},
                                        {31'd0, want.status});
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_word(s_axis_tuser, s_axis_tdata[2:0],
                                    s_axis_tdata[34:3],
                                    s_axis_tdata[66:35],
                                    s_axis_tdata[98:67],
                                    s_axis_tdata[130:99]);
                expected_words.insert(expected_words.size(), want);
            end
        end
        pending = expected_words.size();
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cascaded range remapper: a directed pass over the corner
// cases followed by random scenes of clears, table loads and translations,
// with random stalls on both channels. Checking is done by remap_checker.
// ----------------------------------------------------------------------------
module tb
    import crr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int TARGET_WORDS   = 720;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 240;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int words_sent;
    int idle_cycles;
    int ready_hold;
    bit steady;

    // entries sent for loading since the last clear, used to aim translations
    logic [WORD_W-1:0] known_lo[$];
    logic [WORD_W-1:0] known_len[$];

    always #1 aclk = ~aclk;

    cascaded_range_remapper_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    remap_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // mostly short gaps, a few long ones, none during steady stretches
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // present one word after a random gap and hold it until accepted
    task automatic send_word(logic [1:0] act, logic [2:0] stg, logic [WORD_W-1:0] src,
                             logic [WORD_W-1:0] dst, logic [WORD_W-1:0] len,
                             logic [WORD_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'd0, val, len, dst, src, stg};
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
        if (act == ACT_CLEAR) begin
            known_lo.delete();
            known_len.delete();
        end else if (act == ACT_LOAD) begin
            known_lo.insert(known_lo.size(), src);
            known_len.insert(known_len.size(), len);
        end
    endtask

    task automatic send_load(logic [2:0] stg, logic [WORD_W-1:0] src,
                             logic [WORD_W-1:0] dst, logic [WORD_W-1:0] len);
        send_word(ACT_LOAD, stg, src, dst, len, $urandom);
    endtask

    task automatic send_xlate(logic [WORD_W-1:0] val);
        send_word(ACT_XLATE, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, val);
    endtask

    task automatic send_other(logic [1:0] act);
        send_word(act, 3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
    endtask

    // the edge first lets the checker count the last accepted word
    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // translation value: inside the window, on an entry edge, anywhere, or at zero or all ones
    function automatic logic [WORD_W-1:0] pick_value(logic [WORD_W-1:0] base);
        int r;
        int idx;
        r = $urandom_range(0, 9);
        if (r >= 6 && r <= 7 && known_lo.size() > 0) begin
            idx = $urandom_range(0, known_lo.size() - 1);
            case ($urandom_range(0, 3))
                0: return known_lo[idx];
                1: return known_lo[idx] + known_len[idx] - 1;
                2: return known_lo[idx] + known_len[idx];
                default: return known_lo[idx] - 1;
            endcase
        end
        if (r == 8)
            return $urandom;
        if (r == 9)
            return $urandom_range(0, 1) ? ALL_ONES : '0;
        return base + $urandom_range(0, 8191);
    endfunction

    // one scene: maybe clear, load a few entries per stage, then translate
    task automatic run_scene();
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] len;
        logic [2:0]        stg;
        int                r;
        r = $urandom_range(0, 9);
        if (r < 6)
            base = $urandom & 32'hFFFF_0000;
        else if (r < 8)
            base = '0;
        else
            base = 32'hFFFF_E000;
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 85)
            send_other(ACT_CLEAR);
        for (int s = 0; s < 7; s++) begin
            repeat ($urandom_range(0, 3)) begin
                stg = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'(s);
                len = ($urandom_range(0, 9) == 0) ? '0 : WORD_W'($urandom_range(1, 2048));
                if ($urandom_range(0, 9) == 0)
                    send_load(stg, $urandom, $urandom, $urandom);
                else
                    send_load(stg, base + $urandom_range(0, 4095),
                              base + $urandom_range(0, 4095), len);
            end
        end
        // now and then run one stage past its capacity
        if ($urandom_range(0, 7) == 0) begin
            stg = 3'($urandom_range(0, 6));
            repeat (33)
                send_load(stg, base + $urandom_range(0, 4095),
                          base + $urandom_range(0, 4095), $urandom_range(0, 64));
        end
        repeat ($urandom_range(4, 14)) begin
            if ($urandom_range(0, 14) == 0)
                send_other(ACT_UNUSED);
            send_xlate(pick_value(base));
        end
    endtask

    // result side: random stall stretches
    always @(posedge aclk) begin : rx_stall
        int gap;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_axis_tready) begin
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= gap - 1;
            end else begin
                ready_hold <= $urandom_range(0, 15);
            end
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 15);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** cascaded_range_remapper_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        words_sent     = 0;
        steady         = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners: empty tables, unused code, bad stage, zero length,
        // ranges past the top, destination saturation, clear
        send_xlate(ALL_ONES);
        send_other(ACT_UNUSED);
        send_load(3'd0, 32'd100, 32'd200, 32'd10);
        send_load(3'd7, 32'd100, 32'd300, 32'd10);
        send_load(3'd1, 32'd200, 32'd0, 32'd0);
        send_load(3'd1, 32'd205, 32'd1000, 32'd1);
        send_load(3'd2, 32'd1000, 32'hFFFF_FFFA, 32'd100);
        send_load(3'd6, 32'hFFFF_FFF0, 32'd5, ALL_ONES);
        send_load(3'd5, '0, ALL_ONES, ALL_ONES);
        send_xlate(32'd105);
        send_xlate(32'd100);
        send_xlate(32'd109);
        send_xlate(32'd110);
        send_xlate(32'd99);
        send_xlate(32'd200);
        send_xlate(32'd1010);
        send_xlate(32'hFFFF_FFF0);
        send_xlate(ALL_ONES);
        send_xlate('0);
        send_other(ACT_CLEAR);
        send_xlate(32'd105);
        send_xlate('0);
        send_other(ACT_UNUSED);
        send_other(ACT_CLEAR);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // random scenes, draining now and then before going on
        while (words_sent < TARGET_WORDS) begin
            run_scene();
            if ($urandom_range(0, 2) == 0) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("** cascaded_range_remapper_unit: PASSED **");
        else
            $display("** cascaded_range_remapper_unit: FAILED **");
        $finish;
    end

endmodule

@@ cascaded_range_remapper_unit.f @@
rtl/crr_pkg.sv
rtl/crr_entry_ram.sv
rtl/crr_range_unit.sv
rtl/cascaded_range_remapper_unit.sv
tb/remap_checker.sv
tb/tb.sv
